FILE: hw/rtl/bfmd_pkg.sv
// Shared types and constants for the 2x2 box-filter mip downsampler.
// Holds register codes, reset values, geometry and pipeline word structs.
// Depends on nothing; every other file of the block imports it.
package bfmd_pkg;

    // Default sizing of the line store
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_BPP_DEF   = 16;

    // Fixed limits and field widths
    localparam int HEIGHT_LIMIT = 4096;
    localparam int GEOM_W       = 13;   // width and height registers
    localparam int BPP_W        = 5;    // bytes per pixel register
    localparam int HALF_W       = 12;   // output size minus one
    localparam int ROW_W        = 12;   // row counter
    localparam int PAIR_W       = 9;    // sum of two bytes
    localparam int SUM_W        = 10;   // sum of four bytes
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    // Register reset values
    localparam logic [GEOM_W-1:0] WIDTH_RST  = GEOM_W'(1);
    localparam logic [GEOM_W-1:0] HEIGHT_RST = GEOM_W'(1);
    localparam logic [BPP_W-1:0]  BPP_RST    = BPP_W'(4);

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_BPP    = 2'd2
    } t_reg_idx;

    // Effective geometry after clamping, plus derived values
    typedef struct packed {
        logic              restart;
        logic              w_one;
        logic              h_one;
        logic [GEOM_W-1:0] width;
        logic [GEOM_W-1:0] height;
        logic [BPP_W-1:0]  bpp;
        logic [HALF_W-1:0] dw_m1;
        logic [HALF_W-1:0] dh_m1;
    } t_geom;

    // Word held between the front end and the result register
    typedef struct packed {
        logic              dbl;     // single-row source: use the pair twice
        logic              last;
        logic [PAIR_W-1:0] pair;
    } t_s1;

endpackage

FILE: hw/rtl/box_filter_mip_downsample.sv
// 2x2 box-filter mip downsampler: takes one source level as a byte stream
// and emits the next level down, one rounded component mean per word.
//
// Source channel: i_source_valid / o_source_ready carry one source byte a
// word, in raster order with pixel components interleaved. Result channel:
// o_mip_valid / i_mip_ready carry one output byte and o_level_done, which is
// high on the last byte of the level. Only bytes in odd rows and odd columns
// of the source produce a result; a width of one makes every column count as
// odd, a height of one every row. The APB port sets width, height and bytes
// per pixel; any write to one of them restarts the level at its first byte.
// Write them only idle. Throughput: one source byte per cycle, sustained
// while the receiver takes every result. Each result passes through the
// stage register (with the registered line-store read) and the result
// register; when the receiver stalls, both fill and then o_source_ready
// drops; nothing is lost. Reset clears the counters and the pipeline and
// loads width 1, height 1, 4 bytes per pixel. The line store needs no
// clearing: each even row writes what the next odd row reads.
module box_filter_mip_downsample #(
    parameter int MAX_WIDTH = bfmd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_BPP   = bfmd_pkg::MAX_BPP_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bfmd_pkg::ADDR_W-1:0]  paddr,
    input  logic [bfmd_pkg::DATA_W-1:0]  pwdata,
    output logic [bfmd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_source_valid,
    input  logic [7:0]                   i_source_byte,
    output logic                         o_source_ready,
    output logic                         o_mip_valid,
    output logic [7:0]                   o_mip_byte,
    output logic                         o_level_done,
    input  logic                         i_mip_ready
);
    import bfmd_pkg::*;

    t_geom             w_geom;
    t_s1               w_s1;
    logic              w_s1_valid;
    logic              w_s1_take;
    logic [PAIR_W-1:0] w_line_rd;

    bfmd_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BPP   (MAX_BPP)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (w_geom)
    );

    bfmd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BPP   (MAX_BPP)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (w_geom),
        .i_source_valid (i_source_valid),
        .i_source_byte  (i_source_byte),
        .o_source_ready (o_source_ready),
        .i_s1_take      (w_s1_take),
        .o_s1_valid     (w_s1_valid),
        .o_s1           (w_s1),
        .o_line_rd      (w_line_rd)
    );

    bfmd_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (w_s1_valid),
        .i_s1         (w_s1),
        .i_line_rd    (w_line_rd),
        .o_s1_take    (w_s1_take),
        .o_mip_valid  (o_mip_valid),
        .o_mip_byte   (o_mip_byte),
        .o_level_done (o_level_done),
        .i_mip_ready  (i_mip_ready)
    );

    // A full stage behind a stalled result register must block the source
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_valid && o_mip_valid && !i_mip_ready |-> !o_source_ready)
        else $error("source taken while pipeline is full and stalled");

    // A word leaving the stage always lands in the result register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_take |=> o_mip_valid)
        else $error("stage word lost on its way to the result register");

    // Reset empties both pipeline registers
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_mip_valid && !w_s1_valid)
        else $error("pipeline not empty after reset");

endmodule

FILE: hw/rtl/bfmd_cfg.sv
// APB register bank of the mip downsampler: width, height, bytes per pixel.
// Clamps the registers into effective geometry and flags a level restart.
// Depends on bfmd_pkg.
module bfmd_cfg #(
    parameter int MAX_WIDTH = bfmd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_BPP   = bfmd_pkg::MAX_BPP_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bfmd_pkg::ADDR_W-1:0]  paddr,
    input  logic [bfmd_pkg::DATA_W-1:0]  pwdata,
    output logic [bfmd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output bfmd_pkg::t_geom              o_geom
);
    import bfmd_pkg::*;

    logic [GEOM_W-1:0] r_width;
    logic [GEOM_W-1:0] r_height;
    logic [BPP_W-1:0]  r_bpp;
    logic [1:0]        w_idx;
    logic              w_wr;
    logic              w_listed;
    logic [GEOM_W-1:0] w_width;
    logic [GEOM_W-1:0] w_height;
    logic [BPP_W-1:0]  w_bpp;
    logic [HALF_W-1:0] w_dw;
    logic [HALF_W-1:0] w_dh;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;

    // Decode listed registers
    always_comb begin
        unique case (w_idx)
            REG_WIDTH, REG_HEIGHT, REG_BPP: w_listed = 1'b1;
            default:                        w_listed = 1'b0;
        endcase
    end

    // Hold register values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_bpp    <= BPP_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WIDTH:  r_width  <= pwdata[GEOM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[GEOM_W-1:0];
                REG_BPP:    r_bpp    <= pwdata[BPP_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_HEIGHT: prdata = DATA_W'(r_height);
            REG_BPP:    prdata = DATA_W'(r_bpp);
            default:    prdata = '0;
        endcase
    end

    // Clamp to the supported range; zero acts as one
    always_comb begin
        if (r_width == '0)
            w_width = GEOM_W'(1);
        else if (int'(r_width) > MAX_WIDTH)
            w_width = GEOM_W'(MAX_WIDTH);
        else
            w_width = r_width;

        if (r_height == '0)
            w_height = GEOM_W'(1);
        else if (int'(r_height) > HEIGHT_LIMIT)
            w_height = GEOM_W'(HEIGHT_LIMIT);
        else
            w_height = r_height;

        if (r_bpp == '0)
            w_bpp = BPP_W'(1);
        else if (int'(r_bpp) > MAX_BPP)
            w_bpp = BPP_W'(MAX_BPP);
        else
            w_bpp = r_bpp;
    end

    // Output size is max(1, size >> 1); keep it minus one
    assign w_dw = w_width[GEOM_W-1:1];
    assign w_dh = w_height[GEOM_W-1:1];

    always_comb begin
        o_geom.restart = w_wr && w_listed;
        o_geom.w_one   = (w_width == GEOM_W'(1));
        o_geom.h_one   = (w_height == GEOM_W'(1));
        o_geom.width   = w_width;
        o_geom.height  = w_height;
        o_geom.bpp     = w_bpp;
        o_geom.dw_m1   = (w_dw == '0) ? '0 : w_dw - HALF_W'(1);
        o_geom.dh_m1   = (w_dh == '0) ? '0 : w_dh - HALF_W'(1);
    end

endmodule

FILE: hw/rtl/bfmd_front.sv
// Input side of the mip downsampler: position counters, even-column pixel
// hold, the line store of pair sums and the stage register before output.
// Depends on bfmd_pkg.
module bfmd_front #(
    parameter int MAX_WIDTH = bfmd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_BPP   = bfmd_pkg::MAX_BPP_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bfmd_pkg::t_geom              i_geom,
    input  logic                         i_source_valid,
    input  logic [7:0]                   i_source_byte,
    output logic                         o_source_ready,
    input  logic                         i_s1_take,
    output logic                         o_s1_valid,
    output bfmd_pkg::t_s1                o_s1,
    output logic [bfmd_pkg::PAIR_W-1:0]  o_line_rd
);
    import bfmd_pkg::*;

    localparam int CW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W      = (CW + 1 > GEOM_W) ? CW + 1 : GEOM_W;
    localparam int CPW        = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
    localparam int LINE_DEPTH = (MAX_WIDTH / 2) * MAX_BPP;
    localparam int LIW        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CPW-1:0]    r_comp;
    logic [LIW-1:0]    r_line_idx;
    logic [7:0]        r_hold [MAX_BPP];
    logic [PAIR_W-1:0] r_line_mem [LINE_DEPTH];
    logic [PAIR_W-1:0] r_line_rd;
    logic              r_s1_valid;
    t_s1               r_s1;

    logic              w_acc;
    logic              w_have_pair;
    logic              w_hold_wr;
    logic              w_line_wr;
    logic              w_line_rd;
    logic              w_have_out;
    logic              w_last;
    logic              w_comp_end;
    logic              w_col_end;
    logic              w_row_end;
    logic [PAIR_W-1:0] w_pair;
    logic [CMP_W-1:0]  w_col_inc;
    logic [GEOM_W-1:0] w_row_inc;

    assign o_source_ready = !r_s1_valid || i_s1_take;
    assign w_acc          = i_source_valid && o_source_ready;

    assign w_col_inc = CMP_W'(r_col) + CMP_W'(1);
    assign w_row_inc = GEOM_W'(r_row) + GEOM_W'(1);

    // Horizontal pairing: odd columns close a pair, width one doubles the byte
    assign w_have_pair = i_geom.w_one || r_col[0];
    assign w_hold_wr   = !i_geom.w_one && !r_col[0] && (w_col_inc < CMP_W'(i_geom.width));
    assign w_pair      = i_geom.w_one ? {i_source_byte, 1'b0}
                                      : PAIR_W'(r_hold[r_comp]) + PAIR_W'(i_source_byte);

    // Vertical pairing: even rows park the pair, odd rows fetch it
    assign w_line_wr  = w_have_pair && !i_geom.h_one && !r_row[0] &&
                        (w_row_inc < i_geom.height);
    assign w_line_rd  = w_have_pair && !i_geom.h_one && r_row[0];
    assign w_have_out = w_have_pair && (i_geom.h_one || r_row[0]);

    // Last output byte of the level
    assign w_last = (CMP_W'(r_col >> 1) == CMP_W'(i_geom.dw_m1)) &&
                    ((r_row >> 1) == i_geom.dh_m1) &&
                    (BPP_W'(r_comp) == i_geom.bpp - BPP_W'(1));

    assign w_comp_end = (BPP_W'(r_comp) == i_geom.bpp - BPP_W'(1));
    assign w_col_end  = (w_col_inc >= CMP_W'(i_geom.width));
    assign w_row_end  = (w_row_inc >= i_geom.height);

    // Advance position counters; a register write restarts the level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_geom.restart) begin
            r_col      <= '0;
            r_row      <= '0;
            r_comp     <= '0;
            r_line_idx <= '0;
        end else if (w_acc) begin
            if (w_comp_end) begin
                r_comp <= '0;
                if (w_col_end) begin
                    r_col <= '0;
                    r_row <= w_row_end ? '0 : w_row_inc[ROW_W-1:0];
                end else begin
                    r_col <= w_col_inc[CW-1:0];
                end
            end else begin
                r_comp <= r_comp + CPW'(1);
            end
            if (w_comp_end && w_col_end)
                r_line_idx <= '0;
            else if (w_have_pair)
                r_line_idx <= r_line_idx + LIW'(1);
        end
    end

    // Hold the even-column pixel
    always_ff @(posedge i_clk) begin
        if (w_acc && w_hold_wr)
            r_hold[r_comp] <= i_source_byte;
    end

    // Line store of pair sums from even rows
    always_ff @(posedge i_clk) begin
        if (w_acc && w_line_wr)
            r_line_mem[r_line_idx] <= w_pair;
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_line_rd)
            r_line_rd <= r_line_mem[r_line_idx];
    end

    // Stage register: only words that yield a result enter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_source_ready) begin
            r_s1_valid <= w_acc && w_have_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_have_out) begin
            r_s1.dbl  <= i_geom.h_one;
            r_s1.last <= w_last;
            r_s1.pair <= w_pair;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
    assign o_line_rd  = r_line_rd;

endmodule

FILE: hw/rtl/bfmd_out.sv
// Result stage of the mip downsampler: adds the two pair sums, rounds,
// and holds the result word until the receiver takes it.
// Depends on bfmd_pkg.
module bfmd_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s1_valid,
    input  bfmd_pkg::t_s1                i_s1,
    input  logic [bfmd_pkg::PAIR_W-1:0]  i_line_rd,
    output logic                         o_s1_take,
    output logic                         o_mip_valid,
    output logic [7:0]                   o_mip_byte,
    output logic                         o_level_done,
    input  logic                         i_mip_ready
);
    import bfmd_pkg::*;

    logic             r_valid;
    logic [7:0]       r_mip;
    logic             r_done;
    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_round;
    logic             w_load;

    // Sum of the 2x2 block, then round to nearest
    assign w_sum   = i_s1.dbl ? {i_s1.pair, 1'b0}
                              : SUM_W'(i_line_rd) + SUM_W'(i_s1.pair);
    assign w_round = w_sum + SUM_W'(2);

    assign o_s1_take = i_s1_valid && (!r_valid || i_mip_ready);
    assign w_load    = o_s1_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_mip_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the result word while stalled
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mip  <= w_round[SUM_W-1:2];
            r_done <= i_s1.last;
        end
    end

    assign o_mip_valid  = r_valid;
    assign o_mip_byte   = r_mip;
    assign o_level_done = r_done;

endmodule

FILE: tb/sv/tb_box_filter_mip_downsample.sv
// Self-checking testbench for the 2x2 box-filter mip downsampler.
// Drives source bytes and APB register writes, predicts every mip byte locally
// and checks it on the result channel; depends on bfmd_pkg and the block only.
module tb_box_filter_mip_downsample;
    import bfmd_pkg::*;

    localparam int LINE_DEPTH    = (MAX_WIDTH_DEF / 2) * MAX_BPP_DEF;
    localparam int DRAIN_CYCLES  = 6;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [1:0] REG_UNLISTED = 2'd3;

    typedef struct packed {
        logic [7:0] mip_byte;
        logic       level_done;
    } t_mip_word;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              src_valid;
    logic [7:0]        src_byte;
    logic              src_ready;
    logic              mip_valid;
    logic [7:0]        mip_byte;
    logic              level_done;
    logic              mip_ready;

    // Local copy of the registers and the filter state
    logic [GEOM_W-1:0] width_reg;
    logic [GEOM_W-1:0] height_reg;
    logic [BPP_W-1:0]  bpp_reg;
    logic [PAIR_W-1:0] even_row_sums [0:LINE_DEPTH-1];
    logic [7:0]        even_col_bytes [0:15];
    logic [11:0]       col_pos;
    logic [11:0]       row_pos;
    logic [3:0]        comp_pos;

    t_mip_word expected_mips [$];
    int unsigned fault_count;
    int unsigned stuck_cycles;
    bit          steady_flow;

    box_filter_mip_downsample u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_source_valid (src_valid),
        .i_source_byte  (src_byte),
        .o_source_ready (src_ready),
        .o_mip_valid    (mip_valid),
        .o_mip_byte     (mip_byte),
        .o_level_done   (level_done),
        .i_mip_ready    (mip_ready)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    // Effective geometry after clamping out-of-range register values
    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        return (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0) return 1;
        return (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
    endfunction

    function automatic int unsigned eff_bpp();
        if (bpp_reg == 0) return 1;
        return (bpp_reg > MAX_BPP_DEF) ? MAX_BPP_DEF : bpp_reg;
    endfunction

    function automatic int unsigned level_bytes();
        return eff_width() * eff_height() * eff_bpp();
    endfunction

    // Pair horizontally, then vertically through the line store; queue the mean
    task automatic predict_mip_byte(input logic [7:0] src);
        int unsigned w, h, b, dw, dh, col, row, comp, ox, oy, idx;
        int unsigned pair_sum, quad_sum;
        bit have_pair, have_out;
        t_mip_word word;
        w = eff_width();
        h = eff_height();
        b = eff_bpp();
        dw = (w >> 1) != 0 ? (w >> 1) : 1;
        dh = (h >> 1) != 0 ? (h >> 1) : 1;
        col = col_pos;
        row = row_pos;
        comp = comp_pos;
        ox = 0;
        oy = 0;
        pair_sum = 0;
        quad_sum = 0;
        have_pair = 1'b0;
        have_out = 1'b0;
        if (w == 1) begin
            pair_sum = src * 2;
            have_pair = 1'b1;
        end else if ((col & 1) == 0) begin
            if (col + 1 < w) even_col_bytes[comp] = src;
        end else begin
            pair_sum = even_col_bytes[comp] + src;
            ox = col >> 1;
            have_pair = 1'b1;
        end
        if (have_pair) begin
            idx = ox * b + comp;
            if (idx >= LINE_DEPTH) idx = 0;
            if (h == 1) begin
                quad_sum = pair_sum * 2;
                have_out = 1'b1;
            end else if ((row & 1) == 0) begin
                if (row + 1 < h) even_row_sums[idx] = PAIR_W'(pair_sum);
            end else begin
                quad_sum = even_row_sums[idx] + pair_sum;
                oy = row >> 1;
                have_out = 1'b1;
            end
        end
        if (have_out) begin
            word.mip_byte = 8'((quad_sum + 2) >> 2);
            word.level_done = (ox == dw - 1) && (oy == dh - 1) && (comp == b - 1);
            expected_mips.insert(expected_mips.size(), word);
        end
        // Advance component, column and row, wrapping at the end of the level
        comp++;
        if (comp >= b) begin
            comp = 0;
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        end
        comp_pos = 4'(comp);
        col_pos = 12'(col);
        row_pos = 12'(row);
    endtask

    // Offer one source word, idling first at random unless steady_flow is set; valid stays up after
    task automatic send_source_byte(input logic [7:0] value);
        @(negedge clk);
        while (!steady_flow && $urandom_range(99) < 19) begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_byte <= value;
        do @(posedge clk); while (!src_ready);
        predict_mip_byte(value);
    endtask

    task automatic send_random_bytes(input int unsigned count);
        repeat (count) send_source_byte(8'($urandom_range(255)));
    endtask

    // Drop valid, drain every expected word, then let the pipeline settle
    task automatic wait_block_idle();
        @(negedge clk);
        src_valid <= 1'b0;
        while (expected_mips.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write with noise above the field, then read back and compare
    task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] noisy;
        logic [DATA_W-1:0] want;
        bit listed;
        noisy = $urandom;
        want = '0;
        listed = 1'b1;
        case (idx)
            REG_WIDTH, REG_HEIGHT: begin
                noisy[GEOM_W-1:0] = value[GEOM_W-1:0];
                want[GEOM_W-1:0] = value[GEOM_W-1:0];
            end
            REG_BPP: begin
                noisy[BPP_W-1:0] = value[BPP_W-1:0];
                want[BPP_W-1:0] = value[BPP_W-1:0];
            end
            default: begin
                listed = 1'b0;
            end
        endcase
        wait_block_idle();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= noisy;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // Mirror the write: a listed register restarts the level
        case (idx)
            REG_WIDTH:  width_reg = noisy[GEOM_W-1:0];
            REG_HEIGHT: height_reg = noisy[GEOM_W-1:0];
            REG_BPP:    bpp_reg = noisy[BPP_W-1:0];
            default: ;
        endcase
        if (listed) begin
            col_pos = '0;
            row_pos = '0;
            comp_pos = '0;
        end
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (listed && prdata !== want) begin
            report_fault($sformatf("register %0d read back: expected %h, got %h",
                                   idx, want, prdata));
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reset values: one-pixel level of four components, each byte its own mean
    task automatic test_reset_defaults();
        send_source_byte(8'h00);
        send_source_byte(8'hFF);
        send_source_byte(8'h5A);
        send_source_byte(8'hA5);
        send_source_byte(8'h80);
        send_source_byte(8'h7F);
    endtask

    // Zero in every register acts as one
    task automatic test_zero_registers();
        write_register(REG_WIDTH, 0);
        write_register(REG_HEIGHT, 0);
        write_register(REG_BPP, 0);
        send_source_byte(8'h3C);
        send_source_byte(8'hC3);
    endtask

    // Odd width and height: last column and row are dropped
    task automatic test_odd_edges();
        write_register(REG_WIDTH, 3);
        write_register(REG_HEIGHT, 3);
        write_register(REG_BPP, 2);
        send_random_bytes(18);
    endtask

    // A write beyond the register list must not restart the level
    task automatic test_unlisted_register();
        write_register(REG_WIDTH, 2);
        write_register(REG_HEIGHT, 2);
        write_register(REG_BPP, 1);
        send_random_bytes(2);
        write_register(REG_UNLISTED, $urandom);
        send_random_bytes(2);
    endtask

    // Clamped width and bytes per pixel over the first pixels of a long row
    task automatic test_widest_level();
        write_register(REG_WIDTH, 8191);
        write_register(REG_HEIGHT, 1);
        write_register(REG_BPP, 31);
        send_random_bytes(64);
    endtask

    // Clamped height over a single column: even rows park, odd rows read back
    task automatic test_tallest_level();
        write_register(REG_WIDTH, 1);
        write_register(REG_HEIGHT, 8191);
        write_register(REG_BPP, 1);
        send_random_bytes(40);
    endtask

    // Random small levels: mostly whole, some cut short or resumed
    task automatic test_random_levels();
        int unsigned sent, len, cut, pick;
        logic [GEOM_W-1:0] w_pick;
        logic [GEOM_W-1:0] h_pick;
        logic [BPP_W-1:0]  b_pick;
        sent = 0;
        steady_flow = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS / 3) steady_flow = 1'b0;
            pick = $urandom_range(99);
            if (pick < 5) b_pick = 0;
            else if (pick < 10) b_pick = BPP_W'($urandom_range(17, 31));
            else if (pick < 20) b_pick = 16;
            else b_pick = BPP_W'($urandom_range(1, 6));
            if (b_pick >= 8) begin
                w_pick = GEOM_W'($urandom_range(1, 4));
                h_pick = GEOM_W'($urandom_range(1, 4));
            end else begin
                w_pick = ($urandom_range(19) == 0) ? 0 : GEOM_W'($urandom_range(1, 10));
                h_pick = ($urandom_range(19) == 0) ? 0 : GEOM_W'($urandom_range(1, 8));
            end
            if ($urandom_range(9) < 7) write_register(REG_BPP, b_pick);
            if ($urandom_range(9) < 7) write_register(REG_WIDTH, w_pick);
            if ($urandom_range(9) < 7) write_register(REG_HEIGHT, h_pick);
            len = level_bytes();
            if (len > 256) len = 256;
            if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
            if ($urandom_range(9) < 2) begin
                // Broken sequence: cut short, maybe resumed after an ignored write
                cut = $urandom_range(1, len);
                send_random_bytes(cut);
                sent += cut;
                if ($urandom_range(1) == 1) begin
                    write_register(REG_UNLISTED, $urandom);
                    cut = $urandom_range(0, len);
                    send_random_bytes(cut);
                    sent += cut;
                end
            end else begin
                send_random_bytes(len);
                sent += len;
            end
        end
    endtask

    // Result sink with random back-pressure, always ready while steady_flow is set
    initial begin
        mip_ready = 1'b0;
        forever begin
            @(negedge clk);
            mip_ready <= steady_flow || ($urandom_range(99) >= 19);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        t_mip_word want;
        if (rst_n && mip_valid && mip_ready) begin
            if (expected_mips.size() == 0) begin
                report_fault($sformatf("unexpected mip word: byte %h done %b",
                                       mip_byte, level_done));
            end else begin
                want = expected_mips.pop_front();
                if (mip_byte !== want.mip_byte || level_done !== want.level_done) begin
                    report_fault($sformatf("mip word mismatch: expected byte %h done %b, got byte %h done %b",
                                           want.mip_byte, want.level_done,
                                           mip_byte, level_done));
                end
            end
        end
    end

    // Abort when no word moves for too long
    initial begin
        stuck_cycles = 0;
        while (stuck_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((src_valid && src_ready) || (mip_valid && mip_ready) || psel) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        src_valid = 1'b0;
        src_byte = '0;
        steady_flow = 1'b0;
        fault_count = 0;
        width_reg = WIDTH_RST;
        height_reg = HEIGHT_RST;
        bpp_reg = BPP_RST;
        col_pos = '0;
        row_pos = '0;
        comp_pos = '0;
        foreach (even_col_bytes[i]) even_col_bytes[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_registers();
        test_odd_edges();
        test_unlisted_register();
        test_widest_level();
        test_tallest_level();
        test_random_levels();

        wait_block_idle();
        if (fault_count == 0 && expected_mips.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
